/* rtl/core/dtd_pkg.sv */
package dtd_pkg;

    // table sizes
    localparam int TIMED_SLOTS = 8;
    localparam int READY_SLOTS = 8;

    // index and count widths
    localparam int TIMED_AW = (TIMED_SLOTS > 1) ? $clog2(TIMED_SLOTS) : 1;
    localparam int READY_AW = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;
    localparam int READY_CW = $clog2(READY_SLOTS + 1);

    // field widths
    localparam int OP_W    = 3;
    localparam int ID_W    = 8;
    localparam int DELAY_W = 16;
    localparam int TICK_W  = 32;

    // command codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_SCHEDULE  = 3'd1,
        OP_ENQUEUE   = 3'd2,
        OP_PROCESS   = 3'd3,
        OP_CLR_QUEUE = 3'd4,
        OP_CLR_SCHED = 3'd5
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EMIT_PRE,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/deadline_task_dispatcher_core.sv */
// Deadline task dispatcher: tick counter, timed task table and ready queue.
// Command channel: a command beat (opcode, task_id, delay_ms) is taken at a
// rising edge with start high and busy low. Result channel: each dispatched
// task id shows on run_task_id for one cycle with result_valid high; the
// final beat of a process command also has last_of_run high. The receiver
// cannot stall the block, so results come out back to back.
// Tick, schedule, enqueue and the two clear commands finish in the cycle
// they are taken; busy stays low and the next command may follow at once.
// Process holds busy high while the timed table is walked one slot at a
// time, each slot through a read state (ST_SCAN_RD) and a compare state
// (ST_SCAN_CMP) using the deadline memory read and the single 32-bit
// adder, which also serves tick and schedule and does the due compare; a
// memory prefetch state (ST_EMIT_PRE) then precedes the result beats, one
// per dispatched id.
// Reset (rst_n low, asynchronous) zeroes the tick counter, empties both
// tables and returns the sequencer to idle; no clearing pass is needed.
module deadline_task_dispatcher_core
    import dtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [ID_W-1:0]    task_id,
    input  logic [DELAY_W-1:0] delay_ms,
    output logic               result_valid,
    output logic [ID_W-1:0]    run_task_id,
    output logic               last_of_run
);

    state_t state_reg, state_next;

    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [READY_CW-1:0] cnt_reg, cnt_next;
    logic [TIMED_AW-1:0] scan_idx_reg, scan_idx_next;
    logic [READY_AW-1:0] emit_idx_reg, emit_idx_next;
    logic [ID_W-1:0]     tid_reg  [TIMED_SLOTS];
    logic [ID_W-1:0]     tid_next [TIMED_SLOTS];

    // deadline and ready memories
    logic [TICK_W-1:0]   dl_mem [TIMED_SLOTS];
    logic [TICK_W-1:0]   dl_rd_reg;
    logic                dl_we;
    logic [TIMED_AW-1:0] dl_waddr;
    logic [ID_W-1:0]     rq_mem [READY_SLOTS];
    logic [ID_W-1:0]     rq_rd_reg;
    logic                rq_we;
    logic [READY_AW-1:0] rq_waddr;
    logic [READY_AW-1:0] rq_raddr;
    logic [ID_W-1:0]     rq_wdata;

    // shared adder
    logic [TICK_W-1:0]   alu_b;
    logic                alu_cin;
    logic [TICK_W-1:0]   alu_sum;
    logic                alu_carry;

    logic                free_found;
    logic [TIMED_AW-1:0] free_slot;
    logic                scan_last;
    logic                emit_last;
    logic                queue_full;

    assign scan_last  = (scan_idx_reg == TIMED_AW'(TIMED_SLOTS - 1));
    assign emit_last  = ((READY_CW'(emit_idx_reg) + READY_CW'(1)) == cnt_reg);
    assign queue_full = (cnt_reg >= READY_CW'(READY_SLOTS));

    // first free timed slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = TIMED_SLOTS - 1; k >= 0; k--)
        begin
            if (tid_reg[k] == '0)
            begin
                free_found = 1'b1;
                free_slot  = TIMED_AW'(k);
            end
        end
    end

    // adder operand select: increment, add delay, or subtract for due test
    always_comb
    begin
        alu_b   = TICK_W'(1);
        alu_cin = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (opcode == OP_SCHEDULE)
                    alu_b = TICK_W'(delay_ms);
            end
            ST_SCAN_CMP:
            begin
                alu_b   = ~dl_rd_reg;
                alu_cin = 1'b1;
            end
            default:
            begin
                alu_b   = TICK_W'(1);
                alu_cin = 1'b0;
            end
        endcase
    end

    assign {alu_carry, alu_sum} = {1'b0, tick_reg} + {1'b0, alu_b} + (TICK_W + 1)'(alu_cin);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (opcode == OP_PROCESS))
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
                state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
                state_next = scan_last ? ST_EMIT_PRE : ST_SCAN_RD;
            ST_EMIT_PRE:
                state_next = (cnt_reg == '0) ? ST_IDLE : ST_EMIT;
            ST_EMIT:
            begin
                if (emit_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        tick_next     = tick_reg;
        cnt_next      = cnt_reg;
        scan_idx_next = scan_idx_reg;
        emit_idx_next = emit_idx_reg;
        tid_next      = tid_reg;
        dl_we         = 1'b0;
        dl_waddr      = free_slot;
        rq_we         = 1'b0;
        rq_waddr      = cnt_reg[READY_AW-1:0];
        rq_wdata      = task_id;
        rq_raddr      = '0;
        busy          = (state_reg != ST_IDLE);
        result_valid  = 1'b0;
        run_task_id   = rq_rd_reg;
        last_of_run   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(opcode))
                        OP_TICK:
                            tick_next = alu_sum;
                        OP_SCHEDULE:
                        begin
                            if (free_found && (task_id != '0))
                            begin
                                dl_we               = 1'b1;
                                tid_next[free_slot] = task_id;
                            end
                        end
                        OP_ENQUEUE:
                        begin
                            if (!queue_full && (task_id != '0))
                            begin
                                rq_we    = 1'b1;
                                cnt_next = cnt_reg + READY_CW'(1);
                            end
                        end
                        OP_PROCESS:
                            scan_idx_next = '0;
                        OP_CLR_QUEUE:
                            cnt_next = '0;
                        OP_CLR_SCHED:
                        begin
                            for (int k = 0; k < TIMED_SLOTS; k++)
                                tid_next[k] = '0;
                        end
                        default:
                            tick_next = tick_reg;
                    endcase
                end
            end
            ST_SCAN_CMP:
            begin
                // due entry moves to the queue; lost if the queue is full
                if ((tid_reg[scan_idx_reg] != '0) && alu_carry)
                begin
                    tid_next[scan_idx_reg] = '0;
                    if (!queue_full)
                    begin
                        rq_we    = 1'b1;
                        rq_wdata = tid_reg[scan_idx_reg];
                        cnt_next = cnt_reg + READY_CW'(1);
                    end
                end
                if (!scan_last)
                    scan_idx_next = scan_idx_reg + TIMED_AW'(1);
            end
            ST_EMIT_PRE:
                emit_idx_next = '0;
            ST_EMIT:
            begin
                result_valid = 1'b1;
                last_of_run  = emit_last;
                if (emit_last)
                    cnt_next = '0;
                else
                begin
                    emit_idx_next = emit_idx_reg + READY_AW'(1);
                    rq_raddr      = emit_idx_reg + READY_AW'(1);
                end
            end
            default:
                busy = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            cnt_reg      <= '0;
            scan_idx_reg <= '0;
            emit_idx_reg <= '0;
            for (int k = 0; k < TIMED_SLOTS; k++)
                tid_reg[k] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            cnt_reg      <= cnt_next;
            scan_idx_reg <= scan_idx_next;
            emit_idx_reg <= emit_idx_next;
            tid_reg      <= tid_next;
        end
    end

    // deadline memory, registered read at the scan slot
    always_ff @(posedge clk)
    begin
        if (dl_we)
            dl_mem[dl_waddr] <= alu_sum;
        dl_rd_reg <= dl_mem[scan_idx_reg];
    end

    // ready queue memory, registered read one beat ahead
    always_ff @(posedge clk)
    begin
        if (rq_we)
            rq_mem[rq_waddr] <= rq_wdata;
        rq_rd_reg <= rq_mem[rq_raddr];
    end

endmodule

/* rtl/core/deadline_task_dispatcher_checker.sv */
module deadline_task_dispatcher_checker
    import dtd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [OP_W-1:0]    opcode,
    input logic               result_valid,
    input logic [ID_W-1:0]    run_task_id,
    input logic               last_of_run
);

    // a dispatched id is never the empty mark
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (run_task_id != '0))
        else $error("empty task id dispatched");

    // results only while a process command is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat while idle");

    // every command other than process leaves busy low in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != OP_PROCESS)) |=> !busy)
        else $error("single-cycle command left the block busy");

    // last flag only on a result beat, and nothing follows it
    assert property (@(posedge clk) disable iff (!rst_n)
        last_of_run |-> result_valid)
        else $error("last flag without result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_run) |=> (!result_valid && !busy))
        else $error("beat after last of run");

endmodule

bind deadline_task_dispatcher_core deadline_task_dispatcher_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_valid (result_valid),
    .run_task_id  (run_task_id),
    .last_of_run  (last_of_run)
);
